// ----- rtl/culr_pkg.sv -----
package culr_pkg;

  // fractional bits of the luma scale; the clamp limit follows from it
  localparam int FRACTION_BITS = 2;

  // widths of the arithmetic path
  localparam int SAMPLE_W = 16;
  localparam int LUMA_W   = 10;
  localparam int ACC_W    = 21;  // 16 * 16-bit sample plus rounding, signed
  localparam int OFS_W    = ACC_W - 4;
  localparam int SUM_W    = OFS_W + 1;

  localparam logic signed [SUM_W-1:0] MAX_Y   = SUM_W'((256 << FRACTION_BITS) - 1);
  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(8);

  // packed stream widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic [LUMA_W-1:0] odd;
    logic [LUMA_W-1:0] even;
  } culr_res_t;

endpackage

// ----- rtl/chroma_upsample_luma_refine_top.sv -----
// Chroma upsampler with luma refinement, 9-3-3-1 bilinear weights.
//
// Input stream: one column per beat. in_tdata carries the near-row sample,
// the far-row sample and two base luma values; in_tuser flags the first
// column of a row. A row-start beat (or the first beat after
// reset) only stores the column and gives no output beat. Every other beat
// gives one output beat with the two clamped luma values.
//
// Output: a result is registered in the output register if that is free,
// else in the skid register. Throughput: one column per clock while
// in_tready is high, set by the single registered pass from the input.
//
// Stalls: a two-entry output stage (output register plus skid register)
// sits between the sides. While the receiver holds off, one more result is
// taken into the skid register; in_tready drops only while that is full.
//
// Reset (rst_n low, synchronous) empties the output stage, clears the stored
// column and marks the block unprimed.
module chroma_upsample_luma_refine_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] near_sample, [31:16] far_sample, [41:32] luma_even,
  // [51:42] luma_odd, [55:52] zero
  input  logic [culr_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] row_start
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [9:0] out_even, [19:10] out_odd, [23:20] zero
  output logic [culr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import culr_pkg::*;

  // input field split
  logic signed [SAMPLE_W-1:0] cur_near, cur_far;
  logic [LUMA_W-1:0]          luma_even, luma_odd;
  assign cur_near  = in_tdata[15:0];
  assign cur_far   = in_tdata[31:16];
  assign luma_even = in_tdata[41:32];
  assign luma_odd  = in_tdata[51:42];

  // stored column and priming flag
  logic signed [SAMPLE_W-1:0] prev_near_r, prev_far_r;
  logic                       primed_r;

  // output stage
  logic      out_valid_r, skid_valid_r;
  culr_res_t out_res_r, skid_res_r;
  culr_res_t res;

  logic in_acc, produce, out_free;

  // weighted sum 9*a + 3*b + 3*c + d + 8, floor /16, add luma, clamp
  function automatic logic [LUMA_W-1:0] refine(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic signed [SAMPLE_W-1:0] c,
    input logic signed [SAMPLE_W-1:0] d,
    input logic [LUMA_W-1:0]          luma
  );
    logic signed [ACC_W-1:0] wa, wb, wc, wd, acc;
    logic signed [OFS_W-1:0] ofs;
    logic signed [SUM_W-1:0] sum, lim;
    wa  = ACC_W'(a);
    wb  = ACC_W'(b);
    wc  = ACC_W'(c);
    wd  = ACC_W'(d);
    acc = (wa <<< 3) + wa + (wb <<< 1) + wb + (wc <<< 1) + wc + wd + ROUND_C;
    ofs = acc[ACC_W-1:4];
    sum = $signed({{(SUM_W-LUMA_W){1'b0}}, luma}) + SUM_W'(ofs);
    if (sum[SUM_W-1]) begin
      lim = '0;
    end else if (sum > MAX_Y) begin
      lim = MAX_Y;
    end else begin
      lim = sum;
    end
    return lim[LUMA_W-1:0];
  endfunction

  assign res.even = refine(prev_near_r, cur_near, prev_far_r, cur_far, luma_even);
  assign res.odd  = refine(cur_near, prev_near_r, cur_far, prev_far_r, luma_odd);

  // handshake
  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign produce   = in_acc && !in_tuser && primed_r;
  assign out_free  = !out_valid_r || out_tready;

  // stored column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_near_r <= '0;
      prev_far_r  <= '0;
      primed_r    <= 1'b0;
    end else if (in_acc) begin
      prev_near_r <= cur_near;
      prev_far_r  <= cur_far;
      primed_r    <= 1'b1;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_res_r    <= skid_res_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= produce;
        if (produce) begin
          out_res_r <= res;
        end
      end
    end else if (produce) begin
      skid_valid_r <= 1'b1;
      skid_res_r   <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-2*LUMA_W){1'b0}}, out_res_r.odd, out_res_r.even};

  // skid entry only fills behind a waiting output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a beat while the output register is empty");

  // a priming beat into an empty stage gives no output beat
  a_prime_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser && !out_valid_r && !skid_valid_r) |=> !out_valid_r)
    else $error("row-start beat produced an output beat");

  // any accepted beat leaves the block primed
  a_primed_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> primed_r)
    else $error("block not primed after an accepted beat");

  // a result into an empty stage shows up on the next cycle
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && !out_valid_r) |=> (out_valid_r && !skid_valid_r))
    else $error("result did not reach the output register in one cycle");

endmodule
